// ----- design/tsrl_pkg.sv -----
`default_nettype none
package tsrl_pkg;

  localparam int PRIO_W  = 8;
  localparam int STAMP_W = 16;

  localparam logic [2:0] POL_FCFS    = 3'd0;
  localparam logic [2:0] POL_SJF     = 3'd1;
  localparam logic [2:0] POL_STCF    = 3'd2;
  localparam logic [2:0] POL_RR      = 3'd3;
  localparam logic [2:0] POL_PRIO    = 3'd4;
  localparam logic [2:0] POL_AGING   = 3'd5;
  localparam logic [2:0] POL_CEILING = 3'd6;
  localparam logic [2:0] POL_INHERIT = 3'd7;

  localparam logic [1:0] ERR_OK    = 2'd0;
  localparam logic [1:0] ERR_BAD   = 2'd1;
  localparam logic [1:0] ERR_OWNER = 2'd2;

  localparam logic [0:0] REG_POLICY  = 1'b0;
  localparam logic [0:0] REG_CEILING = 1'b1;

  typedef enum logic [1:0] {
    ACT_ADD  = 2'd0,
    ACT_TICK = 2'd1,
    ACT_ACQ  = 2'd2,
    ACT_REL  = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    PL_IDLE  = 2'd0,
    PL_READY = 2'd1,
    PL_RUN   = 2'd2,
    PL_BLOCK = 2'd3
  } place_t;

  typedef enum logic [1:0] {
    MODE_OLDEST = 2'd0,
    MODE_LIFE   = 2'd1,
    MODE_REMAIN = 2'd2,
    MODE_PRIO   = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    IDX_TID    = 3'd0,
    IDX_RUN    = 3'd1,
    IDX_SCAN   = 3'd2,
    IDX_BEST   = 3'd3,
    IDX_HOLDER = 3'd4
  } isel_t;

  typedef struct packed {
    logic  latch;
    isel_t isel;
    logic  add_write;
    logic  age_write;
    logic  retire;
    logic  requeue;
    logic  block;
    logic  wake;
    logic  choose;
    logic  keep;
    logic  hold_set;
    logic  hold_clr;
    logic  prio_ceil;
    logic  prio_base;
    logic  prio_inh;
    logic  scan_start;
    logic  scan_step;
    logic  scan_ready;
    logic  rptr_zero;
    logic  rptr_inc;
    logic  set_granted;
    logic  set_err1;
    logic  set_err2;
    logic  out_load;
  } cmd_t;

  typedef struct packed {
    action_t    action;
    logic       tid_bad;
    logic       res_bad;
    logic       run_ok;
    logic       holder_is_run;
    logic       holder_is_ret;
    logic       holder_none;
    logic       retire_now;
    logic       scan_last;
    logic       rptr_last;
    logic [2:0] policy;
  } status_t;

endpackage
`default_nettype wire

// ----- design/tsrl_ctrl.sv -----
`default_nettype none
module tsrl_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_tvalid,
  output logic                  in_tready,
  output logic                  out_tvalid,
  input  wire logic             out_tready,
  input  wire tsrl_pkg::status_t st,
  output tsrl_pkg::cmd_t        cmd
);

  typedef enum logic [12:0] {
    S_IDLE   = 13'b0000000000001,
    S_DECODE = 13'b0000000000010,
    S_AGE    = 13'b0000000000100,
    S_RETRES = 13'b0000000001000,
    S_WSCAN  = 13'b0000000010000,
    S_WAKE   = 13'b0000000100000,
    S_SCHED  = 13'b0000001000000,
    S_RSCAN  = 13'b0000010000000,
    S_PICK   = 13'b0000100000000,
    S_ACQ    = 13'b0001000000000,
    S_INH    = 13'b0010000000000,
    S_REL    = 13'b0100000000000,
    S_DONE   = 13'b1000000000000
  } state_t;

  state_t state_r, state_nxt;
  logic   retire_mode_r, retire_mode_nxt;
  logic   out_valid_r, out_valid_nxt;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;

  always_comb begin
    state_nxt       = state_r;
    retire_mode_nxt = retire_mode_r;
    out_valid_nxt   = out_valid_r && !out_tready;
    cmd             = '0;
    cmd.isel        = tsrl_pkg::IDX_RUN;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.latch = 1'b1;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd.isel = tsrl_pkg::IDX_TID;
        case (st.action)
          tsrl_pkg::ACT_ADD: begin
            if (st.tid_bad) cmd.set_err1 = 1'b1;
            else cmd.add_write = 1'b1;
            state_nxt = S_DONE;
          end
          tsrl_pkg::ACT_TICK: state_nxt = S_AGE;
          tsrl_pkg::ACT_ACQ: begin
            if (!st.run_ok || st.res_bad) begin
              cmd.set_err1 = 1'b1;
              state_nxt    = S_DONE;
            end else begin
              state_nxt = S_ACQ;
            end
          end
          default: begin
            if (!st.run_ok || st.res_bad) begin
              cmd.set_err1 = 1'b1;
              state_nxt    = S_DONE;
            end else begin
              state_nxt = S_REL;
            end
          end
        endcase
      end
      S_AGE: begin
        state_nxt = S_SCHED;
        if (st.run_ok) begin
          cmd.age_write = 1'b1;
          if (st.retire_now) begin
            cmd.retire      = 1'b1;
            cmd.rptr_zero   = 1'b1;
            retire_mode_nxt = 1'b1;
            state_nxt       = S_RETRES;
          end
        end
      end
      S_RETRES: begin
        if (st.holder_is_ret) begin
          cmd.hold_clr   = 1'b1;
          cmd.scan_start = 1'b1;
          state_nxt      = S_WSCAN;
        end else if (st.rptr_last) begin
          retire_mode_nxt = 1'b0;
          state_nxt       = S_SCHED;
        end else begin
          cmd.rptr_inc = 1'b1;
        end
      end
      S_WSCAN: begin
        cmd.isel      = tsrl_pkg::IDX_SCAN;
        cmd.scan_step = 1'b1;
        if (st.scan_last) state_nxt = S_WAKE;
      end
      S_WAKE: begin
        cmd.isel = tsrl_pkg::IDX_BEST;
        cmd.wake = 1'b1;
        if (!retire_mode_r) begin
          state_nxt = S_DONE;
        end else if (st.rptr_last) begin
          retire_mode_nxt = 1'b0;
          state_nxt       = S_SCHED;
        end else begin
          cmd.rptr_inc = 1'b1;
          state_nxt    = S_RETRES;
        end
      end
      S_SCHED: begin
        if (st.policy <= tsrl_pkg::POL_SJF && st.run_ok) begin
          cmd.keep  = 1'b1;
          state_nxt = S_DONE;
        end else begin
          cmd.requeue    = st.run_ok;
          cmd.scan_start = 1'b1;
          state_nxt      = S_RSCAN;
        end
      end
      S_RSCAN: begin
        cmd.isel       = tsrl_pkg::IDX_SCAN;
        cmd.scan_step  = 1'b1;
        cmd.scan_ready = 1'b1;
        if (st.scan_last) state_nxt = S_PICK;
      end
      S_PICK: begin
        cmd.isel   = tsrl_pkg::IDX_BEST;
        cmd.choose = 1'b1;
        state_nxt  = S_DONE;
      end
      S_ACQ: begin
        state_nxt = S_DONE;
        if (st.holder_is_run) begin
          cmd.set_granted = 1'b1;
        end else if (st.holder_none) begin
          cmd.hold_set    = 1'b1;
          cmd.set_granted = 1'b1;
          cmd.prio_ceil   = (st.policy == tsrl_pkg::POL_CEILING);
        end else begin
          cmd.block = 1'b1;
          if (st.policy == tsrl_pkg::POL_INHERIT) state_nxt = S_INH;
        end
      end
      S_INH: begin
        cmd.isel     = tsrl_pkg::IDX_HOLDER;
        cmd.prio_inh = 1'b1;
        state_nxt    = S_DONE;
      end
      S_REL: begin
        if (!st.holder_is_run) begin
          cmd.set_err2 = 1'b1;
          state_nxt    = S_DONE;
        end else begin
          cmd.prio_base  = (st.policy >= tsrl_pkg::POL_CEILING);
          cmd.hold_clr   = 1'b1;
          cmd.scan_start = 1'b1;
          state_nxt      = S_WSCAN;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      retire_mode_r <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      retire_mode_r <= retire_mode_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- design/tsrl_dp.sv -----
`default_nettype none
module tsrl_dp #(
  parameter int TASKS     = 16,
  parameter int RESOURCES = 4,
  parameter int LIFE_BITS = 16
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic [31:0]       in_tdata,
  output logic [7:0]             out_tdata,
  input  wire logic              cfg_we,
  input  wire logic [0:0]        cfg_index,
  input  wire logic [7:0]        cfg_wdata,
  input  wire tsrl_pkg::cmd_t    cmd,
  output tsrl_pkg::status_t      st
);

  localparam int TW = $clog2(TASKS);
  localparam int HW = $clog2(TASKS + 1);
  localparam int RW = (RESOURCES > 1) ? $clog2(RESOURCES) : 1;
  localparam int KW = (LIFE_BITS > tsrl_pkg::PRIO_W) ? LIFE_BITS : tsrl_pkg::PRIO_W;
  localparam int SW = tsrl_pkg::STAMP_W;
  localparam int PW = tsrl_pkg::PRIO_W;
  localparam logic [HW-1:0] NONE = HW'(TASKS);

  logic                 used_r  [TASKS];
  tsrl_pkg::place_t     place_r [TASKS];
  logic [RW-1:0]        wait_r  [TASKS];
  logic [SW-1:0]        stamp_r [TASKS];
  logic [LIFE_BITS-1:0] life_r  [TASKS];
  logic [LIFE_BITS-1:0] age_r   [TASKS];
  logic [PW-1:0]        prio_r  [TASKS];
  logic [PW-1:0]        base_r  [TASKS];
  logic [HW-1:0]        holder_r[RESOURCES];

  logic [HW-1:0]        running_r, ret_r, best_r;
  logic                 run_ok_r;
  logic [SW-1:0]        stamp_cnt_r;
  logic [TW-1:0]        sptr_r;
  logic [KW-1:0]        bk_r;
  logic [SW-1:0]        bw_r;
  logic [RW-1:0]        rptr_r;
  logic [PW-1:0]        prio_t_r;
  logic [2:0]           policy_r;
  logic [PW-1:0]        ceil_r;

  tsrl_pkg::action_t    act_r;
  logic [3:0]           tid_r;
  logic [LIFE_BITS-1:0] ilife_r;
  logic [PW-1:0]        iprio_r;
  logic                 res_bad_r;

  logic [3:0]           rnext_r;
  logic                 rvalid_r, rgrant_r;
  logic [1:0]           rerr_r;
  logic [7:0]           out_data_r;

  logic [TW-1:0]        idx, run_idx;
  logic [HW-1:0]        hold_cur;
  logic [LIFE_BITS-1:0] age_inc;
  logic                 cand, better, best_ok;
  tsrl_pkg::mode_t      mode;
  logic [KW-1:0]        key;
  logic [SW-1:0]        waited;

  assign run_idx  = TW'(running_r);
  assign hold_cur = holder_r[rptr_r];
  assign best_ok  = (best_r != NONE);

  always_comb begin
    case (cmd.isel)
      tsrl_pkg::IDX_TID:    idx = TW'(tid_r);
      tsrl_pkg::IDX_RUN:    idx = run_idx;
      tsrl_pkg::IDX_SCAN:   idx = sptr_r;
      tsrl_pkg::IDX_BEST:   idx = TW'(best_r);
      tsrl_pkg::IDX_HOLDER: idx = TW'(hold_cur);
      default:              idx = run_idx;
    endcase
  end

  assign age_inc = (age_r[idx] == {LIFE_BITS{1'b1}}) ? age_r[idx] : age_r[idx] + 1'b1;

  always_comb begin
    if (!cmd.scan_ready) begin
      mode = (policy_r >= tsrl_pkg::POL_PRIO) ? tsrl_pkg::MODE_PRIO : tsrl_pkg::MODE_OLDEST;
    end else begin
      case (policy_r)
        tsrl_pkg::POL_SJF:  mode = tsrl_pkg::MODE_LIFE;
        tsrl_pkg::POL_STCF: mode = tsrl_pkg::MODE_REMAIN;
        tsrl_pkg::POL_FCFS,
        tsrl_pkg::POL_RR:   mode = tsrl_pkg::MODE_OLDEST;
        default:            mode = tsrl_pkg::MODE_PRIO;
      endcase
    end
  end

  always_comb begin
    case (mode)
      tsrl_pkg::MODE_LIFE:   key = KW'(life_r[idx]);
      tsrl_pkg::MODE_REMAIN: key = (age_r[idx] >= life_r[idx]) ? '0 :
                                   KW'(life_r[idx] - age_r[idx]);
      tsrl_pkg::MODE_PRIO:   key = KW'({PW{1'b1}} - prio_r[idx]);
      default:               key = '0;
    endcase
  end

  assign waited = stamp_cnt_r - stamp_r[idx];
  assign cand   = used_r[idx] &&
                  (cmd.scan_ready ? (place_r[idx] == tsrl_pkg::PL_READY) :
                   (place_r[idx] == tsrl_pkg::PL_BLOCK && wait_r[idx] == rptr_r));
  assign better = !best_ok || key < bk_r || (key == bk_r && waited > bw_r);

  always_comb begin
    st.action        = act_r;
    st.tid_bad       = (32'(tid_r) >= TASKS) || used_r[idx];
    st.res_bad       = res_bad_r;
    st.run_ok        = run_ok_r;
    st.holder_is_run = (hold_cur == running_r);
    st.holder_is_ret = (hold_cur == ret_r);
    st.holder_none   = (hold_cur == NONE);
    st.retire_now    = (age_inc >= life_r[idx]);
    st.scan_last     = (sptr_r == TW'(TASKS - 1));
    st.rptr_last     = (rptr_r == RW'(RESOURCES - 1));
    st.policy        = policy_r;
  end

  assign out_tdata = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < TASKS; i++) begin
        used_r[i]  <= 1'b0;
        place_r[i] <= tsrl_pkg::PL_IDLE;
      end
      for (int r = 0; r < RESOURCES; r++) holder_r[r] <= NONE;
      running_r   <= NONE;
      run_ok_r    <= 1'b0;
      stamp_cnt_r <= '0;
      policy_r    <= tsrl_pkg::POL_FCFS;
      ceil_r      <= {PW{1'b1}};
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          tsrl_pkg::REG_POLICY:  policy_r <= cfg_wdata[2:0];
          tsrl_pkg::REG_CEILING: ceil_r   <= cfg_wdata;
          default: ;
        endcase
      end
      if (cmd.add_write) begin
        used_r[idx]  <= 1'b1;
        place_r[idx] <= tsrl_pkg::PL_READY;
        wait_r[idx]  <= '0;
        life_r[idx]  <= ilife_r;
        age_r[idx]   <= '0;
        prio_r[idx]  <= iprio_r;
        base_r[idx]  <= iprio_r;
        stamp_r[idx] <= stamp_cnt_r;
        stamp_cnt_r  <= stamp_cnt_r + 1'b1;
      end
      if (cmd.age_write) age_r[idx] <= age_inc;
      if (cmd.retire) begin
        used_r[idx]  <= 1'b0;
        place_r[idx] <= tsrl_pkg::PL_IDLE;
        ret_r        <= running_r;
        running_r    <= NONE;
        run_ok_r     <= 1'b0;
      end
      if (cmd.requeue) begin
        place_r[idx] <= tsrl_pkg::PL_READY;
        stamp_r[idx] <= stamp_cnt_r;
        stamp_cnt_r  <= stamp_cnt_r + 1'b1;
        run_ok_r     <= 1'b0;
      end
      if (cmd.block) begin
        place_r[idx] <= tsrl_pkg::PL_BLOCK;
        wait_r[idx]  <= rptr_r;
        stamp_r[idx] <= stamp_cnt_r;
        stamp_cnt_r  <= stamp_cnt_r + 1'b1;
        prio_t_r     <= prio_r[idx];
        run_ok_r     <= 1'b0;
      end
      if (cmd.wake && best_ok) begin
        place_r[idx] <= tsrl_pkg::PL_READY;
        stamp_r[idx] <= stamp_cnt_r;
        stamp_cnt_r  <= stamp_cnt_r + 1'b1;
      end
      if (cmd.choose) begin
        running_r <= best_r;
        run_ok_r  <= best_ok;
        if (best_ok) begin
          place_r[idx] <= tsrl_pkg::PL_RUN;
          if (policy_r == tsrl_pkg::POL_AGING) prio_r[idx] <= base_r[idx];
        end
      end
      if (cmd.hold_set) holder_r[rptr_r] <= running_r;
      if (cmd.hold_clr) holder_r[rptr_r] <= NONE;
      if (cmd.prio_ceil) prio_r[idx] <= ceil_r;
      if (cmd.prio_base) prio_r[idx] <= base_r[idx];
      if (cmd.prio_inh && prio_r[idx] < prio_t_r) prio_r[idx] <= prio_t_r;
      if (cmd.scan_step && cand && cmd.scan_ready &&
          policy_r == tsrl_pkg::POL_AGING && prio_r[idx] != {PW{1'b1}}) begin
        prio_r[idx] <= prio_r[idx] + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      act_r     <= tsrl_pkg::action_t'(in_tdata[1:0]);
      tid_r     <= in_tdata[5:2];
      ilife_r   <= LIFE_BITS'(in_tdata[21:6]);
      iprio_r   <= in_tdata[29:22];
      rptr_r    <= RW'(in_tdata[31:30]);
      res_bad_r <= (32'(in_tdata[31:30]) >= RESOURCES);
      rnext_r   <= '0;
      rvalid_r  <= 1'b0;
      rgrant_r  <= 1'b0;
      rerr_r    <= tsrl_pkg::ERR_OK;
    end
    if (cmd.rptr_zero) rptr_r <= '0;
    if (cmd.rptr_inc) rptr_r <= rptr_r + 1'b1;
    if (cmd.scan_start) begin
      sptr_r <= '0;
      best_r <= NONE;
    end
    if (cmd.scan_step) begin
      sptr_r <= sptr_r + 1'b1;
      if (cand && better) begin
        best_r <= HW'(idx);
        bk_r   <= key;
        bw_r   <= waited;
      end
    end
    if (cmd.keep) begin
      rnext_r  <= 4'(running_r);
      rvalid_r <= 1'b1;
    end
    if (cmd.choose && best_ok) begin
      rnext_r  <= 4'(best_r);
      rvalid_r <= 1'b1;
    end
    if (cmd.set_granted) rgrant_r <= 1'b1;
    if (cmd.set_err1) rerr_r <= tsrl_pkg::ERR_BAD;
    if (cmd.set_err2) rerr_r <= tsrl_pkg::ERR_OWNER;
    if (cmd.out_load) out_data_r <= {rerr_r, rgrant_r, rvalid_r, rnext_r};
  end

  a_run_valid: assert property (@(posedge clk) disable iff (!rst_n)
    run_ok_r |-> running_r != NONE)
    else $error("running flag set without a running task");

  a_run_place: assert property (@(posedge clk) disable iff (!rst_n)
    run_ok_r |-> used_r[run_idx] && place_r[run_idx] == tsrl_pkg::PL_RUN)
    else $error("running task is not in the running place");

  a_hold_set: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.hold_set |=> holder_r[$past(rptr_r)] == $past(running_r))
    else $error("resource not handed to the running task");

endmodule
`default_nettype wire

// ----- design/task_scheduler_with_resource_locks.sv -----
// Flow: an add or a rejected item goes from decode straight to the result; an acquire
// passes the acquire state (and the inheritance state), and a release by the holder scans for waiters.
// A tick ages the runner, then scans the ready tasks unless FCFS or SJF keep the runner;
// a retiring runner first visits every resource and wakes a waiter on each one it held.
// One item is in work at a time; the next is accepted in the cycle after the result is loaded.
// Synchronous active-low reset empties the table, frees resources, restores config defaults.
`default_nettype none
module task_scheduler_with_resource_locks #(
  parameter int TASKS     = 16,
  parameter int RESOURCES = 4,
  parameter int LIFE_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // action[1:0], task_id[5:2], lifespan[21:6], base_prio[29:22], res_num[31:30]
  input  wire logic [31:0] in_tdata,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // next_task[3:0], next_valid[4], granted[5], error[7:6]
  output logic [7:0]       out_tdata,
  input  wire logic        cfg_we,
  input  wire logic [0:0]  cfg_index,
  input  wire logic [7:0]  cfg_wdata
);

  tsrl_pkg::cmd_t    cmd;
  tsrl_pkg::status_t st;

  tsrl_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .st         (st),
    .cmd        (cmd)
  );

  tsrl_dp #(
    .TASKS     (TASKS),
    .RESOURCES (RESOURCES),
    .LIFE_BITS (LIFE_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tdata  (in_tdata),
    .out_tdata (out_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .st        (st)
  );

endmodule
`default_nettype wire
